FILE: rtl/crg_pkg.sv
// Shared types, constants and helper functions of the camera ray generator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package crg_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int MAX_PIXEL_DIM = 4096;
   localparam int PIX_W         = 12;
   localparam int ISQRT_STEPS   = 32;
   localparam int DIV_STEPS     = FRAC_BITS + 1;
   localparam int MAT_SLOTS     = 12;

   localparam logic [15:0] HALF_Q16 = 16'h8000;

   localparam logic CMD_RAY  = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam int MODE_AA  = 0;
   localparam int MODE_DOF = 1;

   typedef enum logic [2:0] {
      CSR_EXTENT_X       = 3'd0,
      CSR_EXTENT_Y       = 3'd1,
      CSR_PIXEL_PITCH    = 3'd2,
      CSR_FOCAL_DISTANCE = 3'd3,
      CSR_APERTURE_WIDTH = 3'd4,
      CSR_MODE_FLAGS     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [30:0] extent_x;
      logic [30:0] extent_y;
      logic [30:0] pixel_pitch;
      logic [30:0] focal_distance;
      logic [30:0] aperture_width;
      logic [1:0]  mode_flags;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
      logic [15:0]       jitter_x;
      logic [15:0]       jitter_y;
      logic [15:0]       lens_u;
      logic [15:0]       lens_v;
      logic [3:0]        matrix_slot;
      logic signed [31:0] matrix_word;
   } req_type;

   // Canvas and lens point of a ray, or a matrix load travelling in order.
   typedef struct packed {
      logic              cmd;
      logic [3:0]        slot;
      logic signed [31:0] word;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] lx;
      logic signed [31:0] ly;
   } point_type;

   typedef struct packed {
      logic [2:0]         neg;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [2:0][31:0] mag;
   } diff_type;

   typedef struct packed {
      meta_type         meta;
      logic [2:0][29:0] mag;
      logic [61:0]      sum;
   } norm_type;

   typedef struct packed {
      meta_type         meta;
      logic [2:0][29:0] mag;
      logic [30:0]      len;
   } len_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/crg_front.sv
// Front end: pixel offsets, canvas point and lens point, two register stages.
// Depends on crg_pkg.
`timescale 1ns / 1ps

module crg_front (
   input  logic               clock,
   input  logic               reset,
   input  crg_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  crg_pkg::req_type   in_req,
   output logic               out_valid,
   output crg_pkg::point_type out_point
);

   logic               s1_valid_ff;
   logic               s1_cmd_ff;
   logic [3:0]         s1_slot_ff;
   logic signed [31:0] s1_word_ff;
   logic [42:0]        s1_xa_ff, s1_xa_in, s1_ya_ff, s1_ya_in;
   logic [30:0]        s1_xb_ff, s1_xb_in, s1_yb_ff, s1_yb_in;
   logic [30:0]        s1_lu_ff, s1_lu_in, s1_lv_ff, s1_lv_in;

   logic               s2_valid_ff;
   crg_pkg::point_type s2_point_ff, s2_point_in;

   logic [crg_pkg::PIX_W-1:0] px, py;
   logic [15:0]               fx, fy;
   logic [43:0]               offx, offy;
   logic signed [63:0]        cxw, cyw;
   logic signed [31:0]        half_ap;

   always_comb begin
      px = (32'(in_req.pixel_x) > 32'(crg_pkg::MAX_PIXEL_DIM - 1)) ?
           crg_pkg::PIX_W'(crg_pkg::MAX_PIXEL_DIM - 1) : in_req.pixel_x;
      py = (32'(in_req.pixel_y) > 32'(crg_pkg::MAX_PIXEL_DIM - 1)) ?
           crg_pkg::PIX_W'(crg_pkg::MAX_PIXEL_DIM - 1) : in_req.pixel_y;
      fx = cfg.mode_flags[crg_pkg::MODE_AA] ? in_req.jitter_x : crg_pkg::HALF_Q16;
      fy = cfg.mode_flags[crg_pkg::MODE_AA] ? in_req.jitter_y : crg_pkg::HALF_Q16;
      s1_xa_in = 43'(px) * 43'(cfg.pixel_pitch);
      s1_ya_in = 43'(py) * 43'(cfg.pixel_pitch);
      s1_xb_in = 31'((47'(fx) * 47'(cfg.pixel_pitch)) >> 16);
      s1_yb_in = 31'((47'(fy) * 47'(cfg.pixel_pitch)) >> 16);
      s1_lu_in = 31'((47'(in_req.lens_u) * 47'(cfg.aperture_width)) >> 16);
      s1_lv_in = 31'((47'(in_req.lens_v) * 47'(cfg.aperture_width)) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_cmd_ff  <= in_req.cmd;
      s1_slot_ff <= in_req.matrix_slot;
      s1_word_ff <= in_req.matrix_word;
      s1_xa_ff   <= s1_xa_in;
      s1_ya_ff   <= s1_ya_in;
      s1_xb_ff   <= s1_xb_in;
      s1_yb_ff   <= s1_yb_in;
      s1_lu_ff   <= s1_lu_in;
      s1_lv_ff   <= s1_lv_in;
   end

   always_comb begin
      offx    = 44'(s1_xa_ff) + 44'(s1_xb_ff);
      offy    = 44'(s1_ya_ff) + 44'(s1_yb_ff);
      cxw     = $signed(64'(cfg.extent_x)) - $signed(64'(offx));
      cyw     = $signed(64'(cfg.extent_y)) - $signed(64'(offy));
      half_ap = $signed({2'b00, cfg.aperture_width[30:1]});
      s2_point_in.cmd  = s1_cmd_ff;
      s2_point_in.slot = s1_slot_ff;
      s2_point_in.word = s1_word_ff;
      s2_point_in.cx   = crg_pkg::sat32(cxw);
      s2_point_in.cy   = crg_pkg::sat32(cyw);
      s2_point_in.cz   = -$signed({1'b0, cfg.focal_distance});
      if (cfg.mode_flags[crg_pkg::MODE_DOF]) begin
         s2_point_in.lx = $signed({1'b0, s1_lu_ff}) - half_ap;
         s2_point_in.ly = $signed({1'b0, s1_lv_ff}) - half_ap;
      end else begin
         s2_point_in.lx = '0;
         s2_point_in.ly = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_point_ff <= s2_point_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_point = s2_point_ff;

endmodule

FILE: rtl/crg_xform.sv
// Inverse transform store and affine transform of canvas and lens points,
// then the difference vector. Three register stages. Depends on crg_pkg.
`timescale 1ns / 1ps

module crg_xform (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  crg_pkg::point_type in_point,
   output logic               out_valid,
   output crg_pkg::diff_type  out_diff
);

   logic signed [31:0] mat_ff [crg_pkg::MAT_SLOTS];

   logic               s3_valid_ff;
   logic signed [47:0] cprod_ff [3][3];
   logic signed [47:0] cprod_in [3][3];
   logic signed [47:0] lprod_ff [3][2];
   logic signed [47:0] lprod_in [3][2];
   logic signed [31:0] trans_ff [3];

   logic               s4_valid_ff;
   logic signed [31:0] p_ff [3];
   logic signed [31:0] p_in [3];
   logic signed [31:0] o_ff [3];
   logic signed [31:0] o_in [3];

   logic              s5_valid_ff;
   crg_pkg::diff_type s5_diff_ff, s5_diff_in;

   logic signed [31:0] cvec [3];
   logic signed [31:0] lvec [2];
   logic               load_en;

   assign load_en = in_valid && (in_point.cmd == crg_pkg::CMD_LOAD) &&
                    (32'(in_point.slot) < 32'(crg_pkg::MAT_SLOTS));

   // Loads take effect at this stage, so items keep their order against them.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < crg_pkg::MAT_SLOTS; k++) begin
            mat_ff[k] <= ((k == 0) || (k == 5) || (k == 10)) ?
                         32'sd1 <<< crg_pkg::FRAC_BITS : 32'sd0;
         end
      end else if (load_en) begin
         mat_ff[in_point.slot] <= in_point.word;
      end
   end

   always_comb begin
      logic signed [63:0] full;
      cvec[0] = in_point.cx;
      cvec[1] = in_point.cy;
      cvec[2] = in_point.cz;
      lvec[0] = in_point.lx;
      lvec[1] = in_point.ly;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            full = 64'(mat_ff[i*4+j]) * 64'(cvec[j]);
            cprod_in[i][j] = full[63:crg_pkg::FRAC_BITS];
         end
         for (int j = 0; j < 2; j++) begin
            full = 64'(mat_ff[i*4+j]) * 64'(lvec[j]);
            lprod_in[i][j] = full[63:crg_pkg::FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid && (in_point.cmd == crg_pkg::CMD_RAY);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cprod_ff[i][j] <= cprod_in[i][j];
         end
         for (int j = 0; j < 2; j++) begin
            lprod_ff[i][j] <= lprod_in[i][j];
         end
         trans_ff[i] <= mat_ff[i*4+3];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = crg_pkg::sat32(64'(cprod_ff[i][0]) + 64'(cprod_ff[i][1]) +
                                  64'(cprod_ff[i][2]) + 64'(trans_ff[i]));
         o_in[i] = crg_pkg::sat32(64'(lprod_ff[i][0]) + 64'(lprod_ff[i][1]) +
                                  64'(trans_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         p_ff[i] <= p_in[i];
         o_ff[i] <= o_in[i];
      end
   end

   always_comb begin
      logic signed [32:0] d;
      s5_diff_in.meta.ox = o_ff[0];
      s5_diff_in.meta.oy = o_ff[1];
      s5_diff_in.meta.oz = o_ff[2];
      for (int i = 0; i < 3; i++) begin
         d = 33'(p_ff[i]) - 33'(o_ff[i]);
         s5_diff_in.meta.neg[i] = d[32];
         s5_diff_in.mag[i] = d[32] ? 32'(-d) : 32'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_diff_ff <= s5_diff_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_diff  = s5_diff_ff;

endmodule

FILE: rtl/crg_norm.sv
// Scales the difference magnitudes so the largest, if nonzero, lies in
// [2^29, 2^30), and sums their squares. Five register stages. Depends on crg_pkg.
`timescale 1ns / 1ps

module crg_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crg_pkg::diff_type in_diff,
   output logic              out_valid,
   output crg_pkg::norm_type out_norm
);

   logic              n1_valid_ff;
   crg_pkg::diff_type n1_diff_ff;
   logic [31:0]       n1_max_ff, n1_max_in;

   logic              n2_valid_ff;
   crg_pkg::diff_type n2_diff_ff;
   logic [4:0]        n2_ls_ff, n2_ls_in;
   logic [1:0]        n2_rs_ff, n2_rs_in;

   logic              n3_valid_ff;
   crg_pkg::meta_type n3_meta_ff;
   logic [2:0][29:0]  n3_mag_ff, n3_mag_in;

   logic              n4_valid_ff;
   crg_pkg::meta_type n4_meta_ff;
   logic [2:0][29:0]  n4_mag_ff;
   logic [59:0]       n4_sq_ff [3];

   logic              n5_valid_ff;
   crg_pkg::norm_type n5_norm_ff;

   logic [5:0] blen;

   always_comb begin
      logic [31:0] m01;
      m01 = (in_diff.mag[0] > in_diff.mag[1]) ? in_diff.mag[0] : in_diff.mag[1];
      n1_max_in = (m01 > in_diff.mag[2]) ? m01 : in_diff.mag[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff <= 1'b0;
      end else begin
         n1_valid_ff <= in_valid;
      end
      n1_diff_ff <= in_diff;
      n1_max_ff  <= n1_max_in;
   end

   // Bit length of the largest magnitude sets one common shift for all three.
   always_comb begin
      blen = '0;
      for (int b = 0; b < 32; b++) begin
         if (n1_max_ff[b]) begin
            blen = 6'(b + 1);
         end
      end
      n2_ls_in = '0;
      n2_rs_in = '0;
      if (blen > 6'd30) begin
         n2_rs_in = 2'(blen - 6'd30);
      end else if (blen != 6'd0) begin
         n2_ls_in = 5'(6'd30 - blen);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n2_valid_ff <= 1'b0;
      end else begin
         n2_valid_ff <= n1_valid_ff;
      end
      n2_diff_ff <= n1_diff_ff;
      n2_ls_ff   <= n2_ls_in;
      n2_rs_ff   <= n2_rs_in;
   end

   always_comb begin
      logic [63:0] sh;
      for (int i = 0; i < 3; i++) begin
         sh = (64'(n2_diff_ff.mag[i]) << n2_ls_ff) >> n2_rs_ff;
         n3_mag_in[i] = sh[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n3_valid_ff <= 1'b0;
      end else begin
         n3_valid_ff <= n2_valid_ff;
      end
      n3_meta_ff <= n2_diff_ff.meta;
      n3_mag_ff  <= n3_mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n4_valid_ff <= 1'b0;
      end else begin
         n4_valid_ff <= n3_valid_ff;
      end
      n4_meta_ff <= n3_meta_ff;
      n4_mag_ff  <= n3_mag_ff;
      for (int i = 0; i < 3; i++) begin
         n4_sq_ff[i] <= 60'(n3_mag_ff[i]) * 60'(n3_mag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n5_valid_ff <= 1'b0;
      end else begin
         n5_valid_ff <= n4_valid_ff;
      end
      n5_norm_ff.meta <= n4_meta_ff;
      n5_norm_ff.mag  <= n4_mag_ff;
      n5_norm_ff.sum  <= 62'(n4_sq_ff[0]) + 62'(n4_sq_ff[1]) + 62'(n4_sq_ff[2]);
   end

   assign out_valid = n5_valid_ff;
   assign out_norm  = n5_norm_ff;

endmodule

FILE: rtl/crg_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on crg_pkg.
`timescale 1ns / 1ps

module crg_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crg_pkg::norm_type in_norm,
   output logic              out_valid,
   output crg_pkg::len_type  out_len
);

   localparam int N = crg_pkg::ISQRT_STEPS;

   logic              valid_st [N+1];
   logic [62:0]       rem_st   [N+1];
   logic [62:0]       root_st  [N+1];
   crg_pkg::meta_type meta_st  [N+1];
   logic [2:0][29:0]  mag_st   [N+1];

   assign valid_st[0] = in_valid;
   assign rem_st[0]   = 63'(in_norm.sum);
   assign root_st[0]  = '0;
   assign meta_st[0]  = in_norm.meta;
   assign mag_st[0]   = in_norm.mag;

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [62:0] BIT = 63'(1) << (2 * (N - 1 - k));
      logic [62:0] trial, rem_in, root_in;

      always_comb begin
         trial = root_st[k] + BIT;
         if (rem_st[k] >= trial) begin
            rem_in  = rem_st[k] - trial;
            root_in = (root_st[k] >> 1) + BIT;
         end else begin
            rem_in  = rem_st[k];
            root_in = root_st[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_st[k+1] <= 1'b0;
         end else begin
            valid_st[k+1] <= valid_st[k];
         end
         rem_st[k+1]  <= rem_in;
         root_st[k+1] <= root_in;
         meta_st[k+1] <= meta_st[k];
         mag_st[k+1]  <= mag_st[k];
      end
   end

   assign out_valid    = valid_st[N];
   assign out_len.meta = meta_st[N];
   assign out_len.mag  = mag_st[N];
   assign out_len.len  = root_st[N][30:0];

endmodule

FILE: rtl/crg_div.sv
// Pipelined restoring division of each magnitude by the length, one quotient
// bit per stage, then sign and the result register. Depends on crg_pkg.
`timescale 1ns / 1ps

module crg_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  crg_pkg::len_type    in_len,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_origin_x,
   output logic signed [31:0]  rsp_origin_y,
   output logic signed [31:0]  rsp_origin_z,
   output logic signed [17:0]  rsp_dir_x,
   output logic signed [17:0]  rsp_dir_y,
   output logic signed [17:0]  rsp_dir_z
);

   localparam int N  = crg_pkg::DIV_STEPS;
   localparam int QW = crg_pkg::FRAC_BITS + 1;
   localparam logic [QW-1:0] ONE = QW'(1) << crg_pkg::FRAC_BITS;

   logic                   valid_st [N+1];
   logic [2:0][31:0]       rem_st   [N+1];
   logic [2:0][QW-1:0]     quo_st   [N+1];
   logic [30:0]            len_st   [N+1];
   crg_pkg::meta_type      meta_st  [N+1];

   logic               out_valid_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic signed [17:0] dir_ff [3];
   logic signed [17:0] dir_in [3];

   assign valid_st[0] = in_valid;
   assign len_st[0]   = in_len.len;
   assign meta_st[0]  = in_len.meta;
   assign quo_st[0]   = '0;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_st[0][i] = 32'(in_len.mag[i]);
      end
   end

   // The first step decides the integer bit; later steps shift the remainder.
   for (genvar s = 0; s < N; s++) begin : g_step
      logic [2:0][31:0]   rem_in;
      logic [2:0][QW-1:0] quo_in;

      always_comb begin
         logic [31:0] r;
         for (int i = 0; i < 3; i++) begin
            r = (s == 0) ? rem_st[s][i] : (rem_st[s][i] << 1);
            if (r >= 32'(len_st[s])) begin
               rem_in[i] = r - 32'(len_st[s]);
               quo_in[i] = {quo_st[s][i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = r;
               quo_in[i] = {quo_st[s][i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_st[s+1] <= 1'b0;
         end else begin
            valid_st[s+1] <= valid_st[s];
         end
         rem_st[s+1]  <= rem_in;
         quo_st[s+1]  <= quo_in;
         len_st[s+1]  <= len_st[s];
         meta_st[s+1] <= meta_st[s];
      end
   end

   // A zero length means the pixel point equals the origin.
   always_comb begin
      logic [QW-1:0] u;
      for (int i = 0; i < 3; i++) begin
         u = (quo_st[N][i] > ONE) ? ONE : quo_st[N][i];
         if (len_st[N] == '0) begin
            u = '0;
         end
         dir_in[i] = meta_st[N].neg[i] ? -$signed(18'(u)) : $signed(18'(u));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_st[N];
      end
      ox_ff <= meta_st[N].ox;
      oy_ff <= meta_st[N].oy;
      oz_ff <= meta_st[N].oz;
      for (int i = 0; i < 3; i++) begin
         dir_ff[i] <= dir_in[i];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_origin_x = ox_ff;
   assign rsp_origin_y = oy_ff;
   assign rsp_origin_z = oz_ff;
   assign rsp_dir_x    = dir_ff[0];
   assign rsp_dir_y    = dir_ff[1];
   assign rsp_dir_z    = dir_ff[2];

endmodule

FILE: rtl/camera_ray_generator_core.sv
// Camera ray generator: one item per cycle, never busy, fully pipelined.
// Most of the pipeline depth lies in the 32-stage square root and the
// 17-stage division. Matrix loads give no result. Synchronous reset
// restores the register defaults and the identity transform and empties
// the pipeline.
`timescale 1ns / 1ps

module camera_ray_generator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [11:0]         req_pixel_x,
   input  logic [11:0]         req_pixel_y,
   input  logic [15:0]         req_jitter_x,
   input  logic [15:0]         req_jitter_y,
   input  logic [15:0]         req_lens_u,
   input  logic [15:0]         req_lens_v,
   input  logic [3:0]          req_matrix_slot,
   input  logic signed [31:0]  req_matrix_word,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_origin_x,
   output logic signed [31:0]  rsp_origin_y,
   output logic signed [31:0]  rsp_origin_z,
   output logic signed [17:0]  rsp_dir_x,
   output logic signed [17:0]  rsp_dir_y,
   output logic signed [17:0]  rsp_dir_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [30:0]         csr_data
);

   crg_pkg::cfg_type   cfg_ff;
   crg_pkg::req_type   req;
   crg_pkg::point_type point;
   crg_pkg::diff_type  diff;
   crg_pkg::norm_type  norm;
   crg_pkg::len_type   len;
   logic               accept;
   logic               point_valid, diff_valid, norm_valid, len_valid;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extent_x       <= 31'd65536;
         cfg_ff.extent_y       <= 31'd65536;
         cfg_ff.pixel_pitch    <= 31'd512;
         cfg_ff.focal_distance <= 31'd65536;
         cfg_ff.aperture_width <= '0;
         cfg_ff.mode_flags     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crg_pkg::CSR_EXTENT_X:       cfg_ff.extent_x       <= csr_data;
            crg_pkg::CSR_EXTENT_Y:       cfg_ff.extent_y       <= csr_data;
            crg_pkg::CSR_PIXEL_PITCH:    cfg_ff.pixel_pitch    <= csr_data;
            crg_pkg::CSR_FOCAL_DISTANCE: cfg_ff.focal_distance <= csr_data;
            crg_pkg::CSR_APERTURE_WIDTH: cfg_ff.aperture_width <= csr_data;
            crg_pkg::CSR_MODE_FLAGS:     cfg_ff.mode_flags     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req.cmd         = req_cmd;
      req.pixel_x     = req_pixel_x;
      req.pixel_y     = req_pixel_y;
      req.jitter_x    = req_jitter_x;
      req.jitter_y    = req_jitter_y;
      req.lens_u      = req_lens_u;
      req.lens_v      = req_lens_v;
      req.matrix_slot = req_matrix_slot;
      req.matrix_word = req_matrix_word;
   end

   crg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_req    (req),
      .out_valid (point_valid),
      .out_point (point)
   );

   crg_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (point_valid),
      .in_point  (point),
      .out_valid (diff_valid),
      .out_diff  (diff)
   );

   crg_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_diff   (diff),
      .out_valid (norm_valid),
      .out_norm  (norm)
   );

   crg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_norm   (norm),
      .out_valid (len_valid),
      .out_len   (len)
   );

   crg_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (len_valid),
      .in_len       (len),
      .rsp_valid    (rsp_valid),
      .rsp_origin_x (rsp_origin_x),
      .rsp_origin_y (rsp_origin_y),
      .rsp_origin_z (rsp_origin_z),
      .rsp_dir_x    (rsp_dir_x),
      .rsp_dir_y    (rsp_dir_y),
      .rsp_dir_z    (rsp_dir_z)
   );

endmodule

FILE: sim/testbench.sv
// Testbench for camera_ray_generator_core: directed and random rays and matrix loads,
// each result checked against a fixed-point ray predictor. Depends on rtl/crg_pkg.sv.
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] UNUSED_CSR = 3'd6;
   localparam logic [2:0] SPARE_CSR  = 3'd7;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic signed [31:0] ox, oy, oz;
      logic signed [17:0] dx, dy, dz;
   } ray_type;

   logic clock, reset, start, busy;
   logic req_cmd;
   logic [11:0] req_pixel_x, req_pixel_y;
   logic [15:0] req_jitter_x, req_jitter_y, req_lens_u, req_lens_v;
   logic [3:0] req_matrix_slot;
   logic signed [31:0] req_matrix_word;
   logic rsp_valid;
   logic signed [31:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic signed [17:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [30:0] csr_data;

   // Predictor copy of the block's settings and transform.
   logic [30:0] half_w, half_h, pitch, focal, aperture;
   logic [1:0] modes;
   logic signed [31:0] xform [12];

   ray_type expected_rays[$];
   int errors = 0;
   bit gaps_on = 1;

   camera_ray_generator_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic logic signed [63:0] map_row(input int r, input logic signed [63:0] v0,
                                                  input logic signed [63:0] v1,
                                                  input logic signed [63:0] v2);
      logic signed [63:0] acc, m0, m1, m2, m3;
      m0 = 64'(xform[r*4]);
      m1 = 64'(xform[r*4+1]);
      m2 = 64'(xform[r*4+2]);
      m3 = 64'(xform[r*4+3]);
      acc = ((m0 * v0) >>> 16) + ((m1 * v1) >>> 16) + ((m2 * v2) >>> 16) + m3;
      return clamp32(acc);
   endfunction

   function automatic logic signed [63:0] canvas_axis(input logic [30:0] half,
                                                      input logic [11:0] pix,
                                                      input logic [15:0] frac);
      logic [63:0] off, p, f, h;
      p = 64'(pix);
      f = 64'(frac);
      h = 64'(half);
      off = p * 64'(pitch) + ((f * 64'(pitch)) >> 16);
      return clamp32($signed(h) - $signed(off));
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function automatic ray_type trace_pixel(input logic [11:0] px, input logic [11:0] py,
                                           input logic [15:0] jx, input logic [15:0] jy,
                                           input logic [15:0] lu, input logic [15:0] lv);
      ray_type r;
      logic signed [63:0] cx, cy, cz, lx, ly, pt[3], org[3], d[3];
      logic [63:0] mag[3], top, sum, len, q, a, u, v;
      logic [15:0] fx, fy;
      fx = modes[crg_pkg::MODE_AA] ? jx : crg_pkg::HALF_Q16;
      fy = modes[crg_pkg::MODE_AA] ? jy : crg_pkg::HALF_Q16;
      cx = canvas_axis(half_w, px, fx);
      cy = canvas_axis(half_h, py, fy);
      cz = -$signed({33'd0, focal});
      a = 64'(aperture);
      u = 64'(lu);
      v = 64'(lv);
      lx = 0;
      ly = 0;
      if (modes[crg_pkg::MODE_DOF]) begin
         lx = $signed((u * a) >> 16) - $signed(a >> 1);
         ly = $signed((v * a) >> 16) - $signed(a >> 1);
      end
      top = 0;
      for (int i = 0; i < 3; i++) begin
         pt[i] = map_row(i, cx, cy, cz);
         org[i] = map_row(i, lx, ly, 64'sd0);
         d[i] = pt[i] - org[i];
         mag[i] = d[i] < 0 ? -d[i] : d[i];
         if (mag[i] > top) top = mag[i];
      end
      while (top >= (64'd1 << 30)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top != 0 && top < (64'd1 << 29)) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = root_floor(sum);
      r.ox = org[0][31:0];
      r.oy = org[1][31:0];
      r.oz = org[2][31:0];
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (len != 0) begin
            q = (mag[i] << 16) / len;
            if (q > 64'h1_0000) q = 64'h1_0000;
         end
         if (d[i] < 0) q = -q;
         if (i == 0) r.dx = q[17:0];
         else if (i == 1) r.dy = q[17:0];
         else r.dz = q[17:0];
      end
      return r;
   endfunction

   // Random gap after an item: mostly none or short, now and then long.
   task automatic idle_gap();
      int pick, n;
      pick = $urandom_range(99);
      n = 0;
      if (gaps_on) begin
         if (pick >= 97) n = $urandom_range(60, 20);
         else if (pick >= 88) n = $urandom_range(15, 4);
         else if (pick >= 60) n = $urandom_range(3, 1);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic cmd, input logic [11:0] px, input logic [11:0] py,
                            input logic [15:0] jx, input logic [15:0] jy,
                            input logic [15:0] lu, input logic [15:0] lv,
                            input logic [3:0] slot, input logic [31:0] word);
      start <= 1'b1;
      req_cmd <= cmd;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_jitter_x <= jx;
      req_jitter_y <= jy;
      req_lens_u <= lu;
      req_lens_v <= lv;
      req_matrix_slot <= slot;
      req_matrix_word <= word;
      do @(posedge clock); while (busy);
      if (cmd == crg_pkg::CMD_LOAD) begin
         if (slot < crg_pkg::MAT_SLOTS) xform[slot] = word;
      end else begin
         expected_rays.push_back(trace_pixel(px, py, jx, jy, lu, lv));
      end
      idle_gap();
   endtask

   task automatic cast_ray(input logic [11:0] px, input logic [11:0] py);
      send_item(crg_pkg::CMD_RAY, px, py, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 4'($urandom), $urandom);
   endtask

   task automatic load_entry(input logic [3:0] slot, input logic [31:0] word);
      send_item(crg_pkg::CMD_LOAD, 12'($urandom), 12'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), slot, word);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         crg_pkg::CSR_EXTENT_X:       half_w = value;
         crg_pkg::CSR_EXTENT_Y:       half_h = value;
         crg_pkg::CSR_PIXEL_PITCH:    pitch = value;
         crg_pkg::CSR_FOCAL_DISTANCE: focal = value;
         crg_pkg::CSR_APERTURE_WIDTH: aperture = value;
         crg_pkg::CSR_MODE_FLAGS:     modes = value[1:0];
         default: ;
      endcase
   endtask

   task automatic load_identity();
      for (int s = 0; s < crg_pkg::MAT_SLOTS; s++)
         load_entry(4'(s), (s == 0 || s == 5 || s == 10) ? 32'h1_0000 : 32'h0);
   endtask

   always @(posedge clock) begin
      ray_type e;
      if (!reset && rsp_valid) begin
         if (expected_rays.size() == 0) begin
            report_mismatch("unexpected result count", longint'(1), longint'(0));
         end else begin
            e = expected_rays.pop_front();
            if (rsp_origin_x !== e.ox)
               report_mismatch("origin_x", longint'(rsp_origin_x), longint'(e.ox));
            if (rsp_origin_y !== e.oy)
               report_mismatch("origin_y", longint'(rsp_origin_y), longint'(e.oy));
            if (rsp_origin_z !== e.oz)
               report_mismatch("origin_z", longint'(rsp_origin_z), longint'(e.oz));
            if (rsp_dir_x !== e.dx)
               report_mismatch("dir_x", longint'(rsp_dir_x), longint'(e.dx));
            if (rsp_dir_y !== e.dy)
               report_mismatch("dir_y", longint'(rsp_dir_y), longint'(e.dy));
            if (rsp_dir_z !== e.dz)
               report_mismatch("dir_z", longint'(rsp_dir_z), longint'(e.dz));
         end
      end
   end

   task automatic test_defaults();
      cast_ray(12'd0, 12'd0);
      cast_ray(12'hFFF, 12'hFFF);
      cast_ray(12'd127, 12'd128);
      wait_idle();
   endtask

   task automatic test_extremes();
      write_csr(crg_pkg::CSR_MODE_FLAGS, 31'd3);
      write_csr(crg_pkg::CSR_APERTURE_WIDTH, 31'h7FFF_FFFF);
      write_csr(crg_pkg::CSR_PIXEL_PITCH, 31'h7FFF_FFFF);
      send_item(crg_pkg::CMD_RAY, 12'hFFF, 12'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
                4'd0, 32'd0);
      send_item(crg_pkg::CMD_RAY, 12'd0, 12'hFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                4'd0, 32'd0);
      wait_idle();
      // A canvas point that lands exactly on the origin gives a zero direction.
      write_csr(crg_pkg::CSR_MODE_FLAGS, 31'd0);
      write_csr(crg_pkg::CSR_PIXEL_PITCH, 31'd0);
      write_csr(crg_pkg::CSR_EXTENT_X, 31'd0);
      write_csr(crg_pkg::CSR_EXTENT_Y, 31'd0);
      write_csr(crg_pkg::CSR_FOCAL_DISTANCE, 31'd0);
      cast_ray(12'd5, 12'd9);
      wait_idle();
      write_csr(crg_pkg::CSR_EXTENT_X, 31'h7FFF_FFFF);
      write_csr(crg_pkg::CSR_EXTENT_Y, 31'h7FFF_FFFF);
      write_csr(crg_pkg::CSR_FOCAL_DISTANCE, 31'h7FFF_FFFF);
      write_csr(UNUSED_CSR, 31'h1234);
      write_csr(SPARE_CSR, 31'h7FFF_FFFF);
      cast_ray(12'd0, 12'd0);
      wait_idle();
   endtask

   task automatic test_matrix_loads();
      load_entry(4'd3, 32'h7FFF_FFFF);
      load_entry(4'd7, 32'h8000_0000);
      load_entry(4'd0, 32'h8000_0000);
      load_entry(4'd12, 32'h5555_5555);
      load_entry(4'd15, 32'hFFFF_FFFF);
      cast_ray(12'd1, 12'd2);
      load_identity();
      cast_ray(12'd3, 12'd4);
      wait_idle();
   endtask

   function automatic logic [30:0] pick_setting(input logic [30:0] typical);
      int p;
      p = $urandom_range(9);
      if (p == 0) return 31'h0;
      if (p == 1) return 31'h7FFF_FFFF;
      if (p == 2) return 31'($urandom);
      return typical;
   endfunction

   task automatic test_random(input int phases, input int per_phase);
      logic [31:0] w;
      for (int ph = 0; ph < phases; ph++) begin
         gaps_on = (ph % 4) != 3;
         write_csr(crg_pkg::CSR_EXTENT_X, pick_setting(31'($urandom_range(32'h40_0000))));
         write_csr(crg_pkg::CSR_EXTENT_Y, pick_setting(31'($urandom_range(32'h40_0000))));
         write_csr(crg_pkg::CSR_PIXEL_PITCH, pick_setting(31'($urandom_range(2048))));
         write_csr(crg_pkg::CSR_FOCAL_DISTANCE,
                   pick_setting(31'($urandom_range(32'h4_0000))));
         write_csr(crg_pkg::CSR_APERTURE_WIDTH,
                   pick_setting(31'($urandom_range(32'h2_0000))));
         write_csr(crg_pkg::CSR_MODE_FLAGS, 31'(ph % 4));
         if ($urandom_range(4) == 0) write_csr(3'($urandom_range(7, 6)), 31'($urandom));
         for (int k = 0; k < per_phase; k++) begin
            if ($urandom_range(9) == 0) begin
               // Mostly modest transform entries; sometimes the full word range.
               w = $urandom_range(3) == 0 ? $urandom
                                          : $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
               load_entry(4'($urandom_range(15)), w);
            end else begin
               cast_ray(12'($urandom), 12'($urandom));
            end
         end
         if ($urandom_range(2) == 0) load_identity();
         wait_idle();
      end
      gaps_on = 1;
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= crg_pkg::CMD_RAY;
      req_pixel_x <= '0;
      req_pixel_y <= '0;
      req_jitter_x <= '0;
      req_jitter_y <= '0;
      req_lens_u <= '0;
      req_lens_v <= '0;
      req_matrix_slot <= '0;
      req_matrix_word <= '0;
      csr_valid <= 1'b0;
      csr_index <= crg_pkg::CSR_EXTENT_X;
      csr_data <= '0;
      half_w = 31'd65536;
      half_h = 31'd65536;
      pitch = 31'd512;
      focal = 31'd65536;
      aperture = '0;
      modes = '0;
      for (int s = 0; s < crg_pkg::MAT_SLOTS; s++)
         xform[s] = (s == 0 || s == 5 || s == 10) ? 32'sh1_0000 : 32'sh0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_extremes();
      test_matrix_loads();
      test_random(10, 155);
      wait_idle();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
